// ----- rtl/pba_pkg.sv -----
// Shared constants, request and status codes and the map memory port type
// for the page bitmap allocator. No dependencies.
package pba_pkg;

    localparam int PAGE_COUNT = 65536;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = 2048;
    localparam int PAGE_BYTES = 4096;

    // pages held by the table; pages at or beyond this count as used
    localparam int TABLE_PAGES = (MAP_WORDS * WORD_BITS > PAGE_COUNT) ?
                                 PAGE_COUNT : MAP_WORDS * WORD_BITS;

    localparam int PAGE_W  = $clog2(TABLE_PAGES + 1);
    localparam int WORD_SH = $clog2(WORD_BITS);
    localparam int WADDR_W = $clog2(MAP_WORDS);
    localparam int INDEX_W = 16;
    localparam int COUNT_W = 17;

    localparam logic [1:0] REQ_FREE  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FAIL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic                 re;
        logic [WADDR_W-1:0]   raddr;
        logic                 we;
        logic [WADDR_W-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

endpackage

// ----- rtl/page_bitmap_allocator.sv -----
// Top level of the next-fit page bitmap allocator: request sequencer around
// the bitmap memory. Depends on pba_pkg and pba_map_ram.
//
//  channel | tvalid/tready | tuser          | tdata
//  s_      | request in    | req_type[1:0]  | page_index[15:0], page_count[32:16]
//  m_      | result out    | status[1:0]    | found_page[15:0], page_free[16]
//
// Mark and query read one map word, and mark writes it back when the page was
// free; free and the marking after an allocation read and modify each map word
// touched in turn. The allocation search tests one page a cycle, pausing to read
// each new map word, for up to two passes of the table. After reset a clearing
// pass zeroes every map word; no request is taken meanwhile. A result waiting on
// m_tready holds the sequencer only once the next result is ready.
module page_bitmap_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // page_index[15:0], page_count[32:16], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // found_page[15:0], page_free[16], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int PW = pba_pkg::PAGE_W;
    localparam int WB = pba_pkg::WORD_BITS;
    localparam int WS = pba_pkg::WORD_SH;
    localparam int AW = pba_pkg::WADDR_W;
    localparam int CW = pba_pkg::COUNT_W;
    localparam logic [PW-1:0] TP = PW'(pba_pkg::TABLE_PAGES);

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_RMW, ST_SRD, ST_SCAN, ST_RESP
    } state_t;

    state_t         state_reg;
    logic [AW-1:0]  clr_reg;
    logic [1:0]     req_reg;
    logic [15:0]    idx_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  need_reg;
    logic [PW-1:0]  p_reg;
    logic [PW-1:0]  e_reg;
    logic [PW-1:0]  s0_reg;
    logic [PW-1:0]  rs_reg;
    logic [CW-1:0]  len_reg;
    logic           in_run_reg;
    logic           phase_reg;
    logic [15:0]    nfp_reg;
    logic [1:0]     status_reg;
    logic [15:0]    found_reg;
    logic           pfree_reg;
    logic           m_tvalid_reg;
    logic [23:0]    m_tdata_reg;
    logic [1:0]     m_tuser_reg;

    pba_pkg::mem_req_t mreq;
    logic [WB-1:0]     rdata;

    pba_map_ram u_map (
        .aclk  (aclk),
        .req   (mreq),
        .rdata (rdata)
    );

    logic [15:0]   in_idx;
    logic [CW-1:0] in_cnt;
    logic [17:0]   in_end;
    logic [PW-1:0] in_s0;
    logic          bit_free;
    logic [PW-1:0] base;
    logic [PW-1:0] next_base;
    logic [PW-1:0] pg;
    logic [WB-1:0] rng_mask;
    logic [WB-1:0] bit_mask;
    logic [CW-1:0] run_len;
    logic [PW-1:0] run_start;
    logic          scan_hit;
    logic          scan_fail;
    logic          last_page;

    assign in_idx = s_tdata[15:0];
    assign in_cnt = s_tdata[32:16];
    assign in_end = {2'b00, in_idx} + {1'b0, in_cnt};
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        in_s0 = PW'({1'b0, nfp_reg} + 17'd1);
        if (in_s0 >= TP) begin
            in_s0 = PW'(1);
        end
        bit_free  = rdata[p_reg[WS-1:0]];
        base      = {p_reg[PW-1:WS], {WS{1'b0}}};
        next_base = base + PW'(WB);
        bit_mask  = WB'(1) << p_reg[WS-1:0];
        for (int j = 0; j < WB; j++) begin
            pg = base + PW'(j);
            rng_mask[j] = (pg >= p_reg) && (pg < e_reg);
        end
        run_len   = in_run_reg ? len_reg + CW'(1) : CW'(1);
        run_start = in_run_reg ? rs_reg : p_reg;
        last_page = (p_reg + PW'(1)) == TP;
        scan_hit  = 1'b0;
        scan_fail = 1'b0;
        if (phase_reg == 1'b0) begin
            scan_hit = bit_free && (run_len >= need_reg);
        end else if (bit_free) begin
            scan_fail = run_start >= s0_reg;
            scan_hit  = !scan_fail && (run_len >= need_reg);
        end else begin
            scan_fail = p_reg >= s0_reg;
        end
        if (!scan_hit && phase_reg && last_page) begin
            scan_fail = 1'b1;
        end
    end

    always_comb begin
        mreq       = '0;
        mreq.raddr = p_reg[WS +: AW];
        mreq.re    = (state_reg == ST_RD) || (state_reg == ST_SRD);
        mreq.waddr = p_reg[WS +: AW];
        case (state_reg)
            ST_CLR: begin
                mreq.we    = 1'b1;
                mreq.waddr = clr_reg;
            end
            ST_RMW: begin
                case (req_reg)
                    pba_pkg::REQ_MARK: begin
                        mreq.we    = bit_free;
                        mreq.wdata = rdata & ~bit_mask;
                    end
                    pba_pkg::REQ_QUERY: begin
                        mreq.we = 1'b0;
                    end
                    pba_pkg::REQ_FREE: begin
                        mreq.we    = 1'b1;
                        mreq.wdata = rdata | rng_mask;
                    end
                    default: begin
                        mreq.we    = 1'b1;
                        mreq.wdata = rdata & ~rng_mask;
                    end
                endcase
            end
            default: begin
                mreq.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            nfp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the response state handles m_tvalid itself
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(pba_pkg::MAP_WORDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg    <= s_tuser;
                        idx_reg    <= in_idx;
                        cnt_reg    <= in_cnt;
                        need_reg   <= (in_cnt == '0) ? CW'(1) : in_cnt;
                        status_reg <= (s_tuser != pba_pkg::REQ_ALLOC && PW'(in_idx) >= TP) ?
                                      pba_pkg::STAT_RANGE : pba_pkg::STAT_DONE;
                        found_reg  <= '0;
                        pfree_reg  <= 1'b0;
                        p_reg      <= (s_tuser == pba_pkg::REQ_ALLOC) ? in_s0 : PW'(in_idx);
                        e_reg      <= (in_end >= 18'(TP)) ? TP : PW'(in_end);
                        s0_reg     <= in_s0;
                        in_run_reg <= 1'b0;
                        len_reg    <= '0;
                        phase_reg  <= 1'b0;
                        if (s_tuser == pba_pkg::REQ_ALLOC) begin
                            state_reg <= ST_SRD;
                        end else if (PW'(in_idx) >= TP) begin
                            state_reg <= ST_RESP;
                        end else if (s_tuser == pba_pkg::REQ_FREE && in_cnt == '0) begin
                            state_reg <= ST_RESP;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_RMW;
                end
                ST_RMW: begin
                    case (req_reg)
                        pba_pkg::REQ_MARK: begin
                            if (bit_free) begin
                                nfp_reg <= idx_reg;
                            end else begin
                                status_reg <= pba_pkg::STAT_FAIL;
                            end
                            state_reg <= ST_RESP;
                        end
                        pba_pkg::REQ_QUERY: begin
                            pfree_reg <= bit_free;
                            state_reg <= ST_RESP;
                        end
                        default: begin
                            // advance a word at a time until the range end
                            p_reg <= next_base;
                            if (next_base >= e_reg) begin
                                if (req_reg == pba_pkg::REQ_ALLOC) begin
                                    nfp_reg <= 16'(e_reg - PW'(1));
                                end
                                state_reg <= ST_RESP;
                            end else begin
                                state_reg <= ST_RD;
                            end
                        end
                    endcase
                end
                ST_SRD: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_hit) begin
                        found_reg <= 16'(run_start);
                        if (cnt_reg == '0) begin
                            state_reg <= ST_RESP;
                        end else begin
                            p_reg     <= run_start;
                            e_reg     <= PW'(run_start + PW'(cnt_reg));
                            state_reg <= ST_RD;
                        end
                    end else if (scan_fail) begin
                        status_reg <= pba_pkg::STAT_FAIL;
                        state_reg  <= ST_RESP;
                    end else begin
                        // a run never carries over the wrap
                        in_run_reg <= bit_free && !last_page;
                        if (bit_free) begin
                            rs_reg  <= run_start;
                            len_reg <= run_len;
                        end
                        if (last_page) begin
                            // wrap to page 1 for the second pass
                            phase_reg  <= 1'b1;
                            p_reg      <= PW'(1);
                            state_reg  <= ST_SRD;
                        end else begin
                            p_reg <= p_reg + PW'(1);
                            if ((p_reg[WS-1:0] + WS'(1)) == '0) begin
                                state_reg <= ST_SRD;
                            end
                        end
                    end
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, pfree_reg, found_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // no request is taken while the map is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_tready)
        else $error("request taken during clearing pass");

    // a result appears only out of the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RESP))
        else $error("result without a finished request");

    // the map is written only by the clearing pass or a read-modify-write
    assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.we |-> (state_reg == ST_CLR || state_reg == ST_RMW))
        else $error("unexpected map write");

    // a modify always follows the read of its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW) |-> $past(state_reg == ST_RD))
        else $error("modify without a preceding read");

endmodule

// ----- rtl/pba_map_ram.sv -----
// Free-page bitmap store: one write and one registered read port.
// Depends on pba_pkg.
module pba_map_ram (
    input  logic                          aclk,
    input  pba_pkg::mem_req_t             req,
    output logic [pba_pkg::WORD_BITS-1:0] rdata
);

    logic [pba_pkg::WORD_BITS-1:0] mem [pba_pkg::MAP_WORDS];
    logic [pba_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- bench/tb_page_bitmap_allocator.sv -----
// Self-checking bench for page_bitmap_allocator: a next-fit bitmap predictor,
// a directed part and a random part, with idling on both streams and a long
// result-side hold-off. Depends on pba_pkg and the allocator RTL.
module tb_page_bitmap_allocator;
    import pba_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found;
        logic        pfree;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    page_bitmap_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // predictor state
    bit            page_is_free [0:TABLE_PAGES-1];
    logic [15:0]   fit_ptr;
    alloc_result_t pending_results [$];
    int            error_count;
    bit            no_idle;
    bit            hold_results;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit page_free_at(int p);
        if (p < 0 || p >= TABLE_PAGES) return 1'b0;
        return page_is_free[p];
    endfunction

    function automatic void set_page(int p, bit v);
        if (p >= 0 && p < TABLE_PAGES) page_is_free[p] = v;
    endfunction

    // one lap of next-fit search; run never wraps past the last page
    function automatic bit find_run(int need, output int start);
        int  s0;
        int  rs;
        bit  in_run;
        start = 0;
        rs = 0;
        if (need == 0) need = 1;
        s0 = int'(fit_ptr) + 1;
        if (s0 >= TABLE_PAGES) s0 = 1;
        in_run = 1'b0;
        for (int p = s0; p < TABLE_PAGES; p++) begin
            if (page_is_free[p]) begin
                if (!in_run) begin
                    in_run = 1'b1;
                    rs = p;
                end
                if (p - rs + 1 >= need) begin
                    start = rs;
                    return 1'b1;
                end
            end else begin
                in_run = 1'b0;
            end
        end
        in_run = 1'b0;
        for (int p = 1; p < TABLE_PAGES; p++) begin
            if (page_is_free[p]) begin
                if (!in_run) begin
                    in_run = 1'b1;
                    rs = p;
                end
                if (rs >= s0) break;
                if (p - rs + 1 >= need) begin
                    start = rs;
                    return 1'b1;
                end
            end else begin
                in_run = 1'b0;
                if (p >= s0) break;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_request(logic [1:0] req, int idx, int cnt);
        alloc_result_t r;
        int rs;
        r = '0;
        r.status = STAT_DONE;
        case (req)
            REQ_FREE: begin
                if (idx >= TABLE_PAGES) r.status = STAT_RANGE;
                else for (int i = 0; i < cnt && idx + i < TABLE_PAGES; i++) set_page(idx + i, 1'b1);
            end
            REQ_ALLOC: begin
                if (find_run(cnt, rs)) begin
                    r.found = rs[15:0];
                    if (cnt > 0) begin
                        for (int i = 0; i < cnt; i++) set_page(rs + i, 1'b0);
                        fit_ptr = 16'(rs + cnt - 1);
                    end
                end else begin
                    r.status = STAT_FAIL;
                end
            end
            REQ_MARK: begin
                if (idx >= TABLE_PAGES) r.status = STAT_RANGE;
                else if (!page_free_at(idx)) r.status = STAT_FAIL;
                else begin
                    set_page(idx, 1'b0);
                    fit_ptr = 16'(idx);
                end
            end
            default: begin
                if (idx >= TABLE_PAGES) r.status = STAT_RANGE;
                else r.pfree = page_free_at(idx);
            end
        endcase
        return r;
    endfunction

    task automatic send_request(logic [1:0] req, int idx, int cnt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, 17'(cnt), 16'(idx)};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_request(req, idx, cnt));
    endtask

    // result side: random stall per transfer, or one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_results = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d found=%0d free=%0d",
                         $time, m_tuser, m_tdata[15:0], m_tdata[16]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[15:0] !== want.found) begin
                    $display("%0t: found_page expected %0d actual %0d",
                             $time, want.found, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[16] !== want.pfree) begin
                    $display("%0t: page_free expected %0d actual %0d",
                             $time, want.pfree, m_tdata[16]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_map();
        send_request(REQ_QUERY, 0, 0);
        send_request(REQ_QUERY, 16'hFFFF, 17'h1FFFF);
        send_request(REQ_ALLOC, 0, 1);          // no space: every page used
        send_request(REQ_MARK, 5, 0);           // already used
        send_request(REQ_FREE, 10, 0);          // zero pages
        send_request(REQ_QUERY, 10, 0);
    endtask

    task automatic test_free_edges();
        send_request(REQ_FREE, 65530, 100);     // runs past the table end
        send_request(REQ_QUERY, 65535, 0);
        send_request(REQ_QUERY, 65529, 0);
        send_request(REQ_FREE, 0, 65536);
        send_request(REQ_QUERY, 0, 0);
    endtask

    task automatic test_alloc_edges();
        send_request(REQ_ALLOC, 16'hFFFF, 0);   // first free page, nothing marked
        send_request(REQ_ALLOC, 0, 65535);      // whole table bar page 0
        send_request(REQ_ALLOC, 0, 1);          // no space left
        send_request(REQ_FREE, 0, 65536);
        send_request(REQ_ALLOC, 0, 65536);      // can never fit
        send_request(REQ_MARK, 0, 0);
        send_request(REQ_MARK, 0, 0);
        send_request(REQ_MARK, 65535, 0);
        send_request(REQ_MARK, 65530, 0);
        send_request(REQ_ALLOC, 0, 8);          // tail run too short, wrap to page 1
        send_request(REQ_ALLOC, 0, 4);
        send_request(REQ_QUERY, 65531, 0);
    endtask

    task automatic test_backpressure();
        hold_results = 1'b1;
        for (int i = 0; i < 40; i++) send_request(REQ_QUERY, $urandom_range(0, 65535), 0);
    endtask

    task automatic test_random_mix(int items);
        int  kind;
        int  cnt;
        send_request(REQ_FREE, 0, 65536);
        for (int i = 0; i < items; i++) begin
            // stretches without idling
            no_idle = ((i % 150) >= 100);
            if (i % 250 == 249) send_request(REQ_FREE, 0, 65536);
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 512) : $urandom_range(0, 8);
                send_request(REQ_ALLOC, $urandom_range(0, 65535), cnt);
            end else if (kind < 55) begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17'h1FFFF)
                                                  : $urandom_range(0, 64);
                send_request(REQ_FREE, $urandom_range(0, 65535), cnt);
            end else if (kind < 80) begin
                send_request(REQ_MARK, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF));
            end else begin
                send_request(REQ_QUERY, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count  = 0;
        no_idle      = 1'b0;
        hold_results = 1'b0;
        fit_ptr      = '0;
        foreach (page_is_free[p]) page_is_free[p] = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_FREE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_map();
        test_free_edges();
        test_alloc_edges();
        test_backpressure();
        test_random_mix(1000);

        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
